// ===== sv/vldr_pkg.sv =====
`timescale 1ns / 1ps
package vldr_pkg;

    localparam int LANES     = 8;
    localparam int DATA_BITS = 32;
    localparam int WARP_BITS = 3;
    localparam int LANE_BITS = 3;
    localparam int KIND_BITS = 2;

    localparam logic [KIND_BITS-1:0] KIND_DIVU = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_REMU = 2'd1;

    typedef struct packed {
        logic [WARP_BITS-1:0] warp_number;
        logic [LANE_BITS-1:0] lane_index;
        logic                 final_lane;
        logic                 lane_active;
        logic                 vector_form;
        logic [KIND_BITS-1:0] kind;
        logic                 swap_operands;
        logic                 use_broadcast;
        logic                 writes_back;
        logic [DATA_BITS-1:0] first_operand;
        logic [DATA_BITS-1:0] second_operand;
        logic [DATA_BITS-1:0] broadcast_operand;
    } in_beat_t;

    typedef struct packed {
        logic [WARP_BITS-1:0] result_warp;
        logic [LANE_BITS-1:0] result_lane;
        logic                 result_last;
        logic                 lane_written;
        logic [DATA_BITS-1:0] lane_value;
    } out_beat_t;

    typedef struct packed {
        logic [WARP_BITS-1:0] warp;
        logic [LANE_BITS-1:0] lane;
        logic                 last;
        logic                 written;
        logic                 is_rem;
    } lane_tag_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] rem;
        logic [DATA_BITS-1:0] quo;
        logic [DATA_BITS-1:0] div;
        lane_tag_t            tag;
    } div_slot_t;

endpackage

// ===== sv/vldr_div_step.sv =====
`timescale 1ns / 1ps
module vldr_div_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  vldr_pkg::div_slot_t in_slot,
    output logic                out_valid,
    output vldr_pkg::div_slot_t out_slot
);
    import vldr_pkg::*;

    logic                 valid_reg;
    div_slot_t            slot_reg;
    div_slot_t            slot_next;
    logic [DATA_BITS:0]   partial;
    logic [DATA_BITS:0]   trial;

    // one restoring step: shift in the next dividend bit, try the subtract
    always_comb
    begin
        slot_next = in_slot;
        partial   = {in_slot.rem, in_slot.quo[DATA_BITS-1]};
        trial     = partial - {1'b0, in_slot.div};
        if (!trial[DATA_BITS])
        begin
            slot_next.rem = trial[DATA_BITS-1:0];
            slot_next.quo = {in_slot.quo[DATA_BITS-2:0], 1'b1};
        end
        else
        begin
            slot_next.rem = partial[DATA_BITS-1:0];
            slot_next.quo = {in_slot.quo[DATA_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            slot_reg <= slot_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_slot  = slot_reg;

endmodule

// ===== sv/vector_lane_unsigned_div_rem_unit.sv =====
`timescale 1ns / 1ps
// Unsigned divide / remainder for one thread lane per beat. A beat enters in
// every cycle unless the output stalls, and passes through one operand-select
// stage followed by a 32-stage restoring divider that retires one quotient bit
// per stage. The whole pipeline advances together whenever the output beat is
// taken or absent, so a stall on the output holds every stage. Beats whose
// instruction writes nothing are consumed and produce no result. Division by
// zero gives an all-ones quotient and returns the dividend as remainder.
module vector_lane_unsigned_div_rem_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vldr_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vldr_pkg::out_beat_t out_data
);
    import vldr_pkg::*;

    logic                 advance;
    logic                 prep_valid_reg;
    div_slot_t            prep_slot_reg;
    div_slot_t            prep_slot_next;
    logic                 lane_ok;
    logic                 compute;
    logic                 kind_ok;
    logic [DATA_BITS-1:0] dividend;
    logic [DATA_BITS-1:0] divisor;

    logic                 step_valid [DATA_BITS+1];
    div_slot_t            step_slot  [DATA_BITS+1];
    div_slot_t            tail;

    assign advance  = !step_valid[DATA_BITS] || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        case (in_data.kind)
            KIND_DIVU: kind_ok = 1'b1;
            KIND_REMU: kind_ok = 1'b1;
            default:   kind_ok = 1'b0;
        endcase
        lane_ok  = (32'(in_data.lane_index) < 32'(LANES));
        dividend = in_data.first_operand;
        divisor  = in_data.second_operand;
        if (in_data.vector_form)
        begin
            compute = in_data.lane_active;
            if (in_data.swap_operands)
            begin
                dividend = in_data.second_operand;
                if (in_data.kind == KIND_REMU && in_data.use_broadcast)
                begin
                    divisor = in_data.broadcast_operand;
                end
                else
                begin
                    divisor = in_data.first_operand;
                end
            end
        end
        else
        begin
            compute = (in_data.lane_index == '0);
        end

        prep_slot_next             = '0;
        prep_slot_next.rem         = '0;
        prep_slot_next.quo         = dividend;
        prep_slot_next.div         = divisor;
        prep_slot_next.tag.warp    = in_data.warp_number;
        prep_slot_next.tag.lane    = in_data.lane_index;
        prep_slot_next.tag.last    = in_data.final_lane;
        prep_slot_next.tag.written = kind_ok && lane_ok && compute;
        prep_slot_next.tag.is_rem  = (in_data.kind == KIND_REMU);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            prep_valid_reg <= in_valid && in_data.writes_back;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prep_slot_reg <= prep_slot_next;
        end
    end

    assign step_valid[0] = prep_valid_reg;
    assign step_slot[0]  = prep_slot_reg;

    for (genvar i = 0; i < DATA_BITS; i++)
    begin : g_step
        vldr_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .in_valid (step_valid[i]),
            .in_slot  (step_slot[i]),
            .out_valid(step_valid[i+1]),
            .out_slot (step_slot[i+1])
        );
    end

    assign tail                  = step_slot[DATA_BITS];
    assign out_valid             = step_valid[DATA_BITS];
    assign out_data.result_warp  = tail.tag.warp;
    assign out_data.result_lane  = tail.tag.lane;
    assign out_data.result_last  = tail.tag.last;
    assign out_data.lane_written = tail.tag.written;
    assign out_data.lane_value   = !tail.tag.written ? '0 :
                                   (tail.tag.is_rem ? tail.rem : tail.quo);

    a_empty_tail_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline stalled with no output beat pending");

    a_no_writeback_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_data.writes_back |=> !prep_valid_reg)
        else $error("beat without writeback entered the pipeline");

    a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> step_valid[DATA_BITS-1] == $past(step_valid[DATA_BITS-1])
                     && prep_valid_reg == $past(prep_valid_reg))
        else $error("pipeline moved during a stall");

    a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.lane_written |-> out_data.lane_value == '0)
        else $error("unwritten lane carries a nonzero value");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import vldr_pkg::*;

    localparam logic [KIND_BITS-1:0] KIND_UNDEF_A = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_UNDEF_B = 2'd3;
    localparam int PIPE_DEPTH   = 33;
    localparam int DRAIN_CYCLES = PIPE_DEPTH + 8;
    localparam int HOLD_CYCLES  = 250;
    localparam int CYCLE_LIMIT  = 200000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;

    out_beat_t expected_lane_results[$];
    out_beat_t want_beat;
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        writing_beats_sent = 0;
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    logic      holding = 1'b0;
    event      hold_go;

    vector_lane_unsigned_div_rem_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic predict_lane_result(input in_beat_t beat, output out_beat_t res);
        logic [DATA_BITS-1:0] num;
        logic [DATA_BITS-1:0] den;
        logic                 computes;
        res = '0;
        if (!beat.writes_back)
            return 1'b0;
        res.result_warp = beat.warp_number;
        res.result_lane = beat.lane_index;
        res.result_last = beat.final_lane;
        num = beat.first_operand;
        den = beat.second_operand;
        computes = 1'b0;
        if ((beat.kind == KIND_DIVU || beat.kind == KIND_REMU) && beat.lane_index < LANES)
        begin
            if (beat.vector_form)
            begin
                if (beat.lane_active)
                begin
                    computes = 1'b1;
                    if (beat.swap_operands)
                    begin
                        num = beat.second_operand;
                        den = (beat.kind == KIND_REMU && beat.use_broadcast) ?
                              beat.broadcast_operand : beat.first_operand;
                    end
                end
            end
            else if (beat.lane_index == 0)
                computes = 1'b1;
        end
        if (computes)
        begin
            res.lane_written = 1'b1;
            if (beat.kind == KIND_DIVU)
                res.lane_value = (den == 0) ? '1 : num / den;
            else
                res.lane_value = (den == 0) ? num : num % den;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_BITS-1:0] got,
                                   input logic [DATA_BITS-1:0] want);
        mismatch_count++;
        $display("MISMATCH cycle %0d %s: got %h expected %h", cycle_count, what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid === 1'b1 && out_ready)
            begin
                if (expected_lane_results.size() == 0)
                    report_mismatch("unexpected beat", out_data.lane_value, '0);
                else
                begin
                    want_beat = expected_lane_results.pop_front();
                    if (out_data.result_warp !== want_beat.result_warp)
                        report_mismatch("result_warp", DATA_BITS'(out_data.result_warp),
                                        DATA_BITS'(want_beat.result_warp));
                    if (out_data.result_lane !== want_beat.result_lane)
                        report_mismatch("result_lane", DATA_BITS'(out_data.result_lane),
                                        DATA_BITS'(want_beat.result_lane));
                    if (out_data.result_last !== want_beat.result_last)
                        report_mismatch("result_last", DATA_BITS'(out_data.result_last),
                                        DATA_BITS'(want_beat.result_last));
                    if (out_data.lane_written !== want_beat.lane_written)
                        report_mismatch("lane_written", DATA_BITS'(out_data.lane_written),
                                        DATA_BITS'(want_beat.lane_written));
                    if (out_data.lane_value !== want_beat.lane_value)
                        report_mismatch("lane_value", out_data.lane_value,
                                        want_beat.lane_value);
                end
            end
            out_ready <= !holding && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(hold_go);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    task automatic send_beat(input in_beat_t beat);
        out_beat_t want;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        if (predict_lane_result(beat, want))
            expected_lane_results.push_back(want);
        if (beat.writes_back)
            writing_beats_sent++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_lane_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [DATA_BITS-1:0] pick_operand();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return $urandom_range(15);
            3: return $urandom_range(255);
            4: return 32'd1 << $urandom_range(31);
            5: return $urandom >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    function automatic in_beat_t op_beat(input logic [KIND_BITS-1:0] kind, input logic vec,
                                         input logic [LANE_BITS-1:0] lane,
                                         input logic [DATA_BITS-1:0] a,
                                         input logic [DATA_BITS-1:0] b);
        in_beat_t beat;
        beat                   = '0;
        beat.warp_number       = WARP_BITS'($urandom_range(7));
        beat.lane_index        = lane;
        beat.final_lane        = 1'b1;
        beat.lane_active       = 1'b1;
        beat.vector_form       = vec;
        beat.kind              = kind;
        beat.writes_back       = 1'b1;
        beat.first_operand     = a;
        beat.second_operand    = b;
        beat.broadcast_operand = $urandom;
        return beat;
    endfunction

    task automatic send_instruction();
        in_beat_t             beat;
        int                   lane_count;
        int                   pick;
        logic [DATA_BITS-1:0] lane0_first;
        beat = '0;
        beat.warp_number = WARP_BITS'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 45)
            beat.kind = KIND_DIVU;
        else if (pick < 90)
            beat.kind = KIND_REMU;
        else if (pick < 95)
            beat.kind = KIND_UNDEF_A;
        else
            beat.kind = KIND_UNDEF_B;
        beat.vector_form   = $urandom_range(99) < 80;
        beat.swap_operands = 1'($urandom_range(1));
        beat.use_broadcast = 1'($urandom_range(1));
        beat.writes_back   = $urandom_range(99) < 92;
        if (beat.vector_form || $urandom_range(99) < 10)
            lane_count = $urandom_range(1, LANES);
        else
            lane_count = 1;
        lane0_first = pick_operand();
        for (int i = 0; i < lane_count; i++)
        begin
            beat.lane_index        = LANE_BITS'(i);
            beat.final_lane        = (i == lane_count - 1);
            beat.lane_active       = $urandom_range(99) < 75;
            beat.first_operand     = (i == 0) ? lane0_first : pick_operand();
            beat.second_operand    = pick_operand();
            beat.broadcast_operand = lane0_first;
            send_beat(beat);
        end
    endtask

    task automatic send_noise();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        send_beat(bits[$bits(in_beat_t)-1:0]);
    endtask

    task automatic run_random_traffic(input int idle_pct, input int stall_pct, input int beats);
        int target;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        target = writing_beats_sent + beats;
        while (writing_beats_sent < target)
        begin
            if ($urandom_range(99) < 10)
                send_noise();
            else
                send_instruction();
        end
        wait_for_results();
    endtask

    task automatic test_directed();
        in_beat_t beat;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_beat(op_beat(KIND_DIVU, 1'b1, 3'd0, 32'd100, 32'd7));
        send_beat(op_beat(KIND_REMU, 1'b1, 3'd1, 32'd100, 32'd7));
        send_beat(op_beat(KIND_DIVU, 1'b1, 3'd2, 32'h1234_5678, 32'd0));
        send_beat(op_beat(KIND_REMU, 1'b1, 3'd3, 32'h1234_5678, 32'd0));
        send_beat(op_beat(KIND_DIVU, 1'b1, 3'd4, 32'hffff_ffff, 32'd1));
        send_beat(op_beat(KIND_DIVU, 1'b1, 3'd5, 32'hffff_ffff, 32'hffff_ffff));
        send_beat(op_beat(KIND_DIVU, 1'b1, 3'd6, 32'd0, 32'd5));
        send_beat(op_beat(KIND_REMU, 1'b1, 3'd7, 32'hffff_ffff, 32'h8000_0000));
        beat = op_beat(KIND_DIVU, 1'b1, 3'd1, 32'd3, 32'hdead_beef);
        beat.swap_operands = 1'b1;
        send_beat(beat);
        beat = op_beat(KIND_REMU, 1'b1, 3'd2, 32'd9, 32'hdead_beef);
        beat.swap_operands = 1'b1;
        beat.use_broadcast = 1'b1;
        beat.broadcast_operand = 32'd1000;
        send_beat(beat);
        beat.broadcast_operand = '0;
        send_beat(beat);
        beat = op_beat(KIND_DIVU, 1'b1, 3'd3, 32'd6, 32'd600);
        beat.swap_operands = 1'b1;
        beat.use_broadcast = 1'b1;
        beat.broadcast_operand = 32'd7;
        send_beat(beat);
        beat = op_beat(KIND_REMU, 1'b1, 3'd4, 32'd77, 32'd10);
        beat.use_broadcast = 1'b1;
        beat.broadcast_operand = 32'd3;
        send_beat(beat);
        beat = op_beat(KIND_DIVU, 1'b1, 3'd5, 32'd50, 32'd5);
        beat.lane_active = 1'b0;
        send_beat(beat);
        beat = op_beat(KIND_DIVU, 1'b0, 3'd0, 32'd50, 32'd4);
        beat.lane_active = 1'b0;
        beat.swap_operands = 1'b1;
        beat.use_broadcast = 1'b1;
        send_beat(beat);
        send_beat(op_beat(KIND_REMU, 1'b0, 3'd5, 32'd50, 32'd4));
        send_beat(op_beat(KIND_UNDEF_A, 1'b1, 3'd1, 32'd50, 32'd4));
        send_beat(op_beat(KIND_UNDEF_B, 1'b0, 3'd0, 32'd50, 32'd4));
        beat = op_beat(KIND_DIVU, 1'b1, 3'd2, 32'd50, 32'd4);
        beat.writes_back = 1'b0;
        send_beat(beat);
        beat = op_beat(KIND_REMU, 1'b0, 3'd0, 32'd50, 32'd4);
        beat.writes_back = 1'b0;
        send_beat(beat);
        beat = op_beat(KIND_REMU, 1'b1, 3'd7, 32'hffff_fffe, 32'hffff_ffff);
        beat.warp_number = 3'd7;
        send_beat(beat);
        beat = op_beat(KIND_DIVU, 1'b1, 3'd0, 32'd1, 32'hffff_ffff);
        beat.warp_number = 3'd0;
        beat.final_lane = 1'b0;
        send_beat(beat);
        wait_for_results();
    endtask

    task automatic test_pause_until_drained();
        sender_idle_pct    = 0;
        receiver_stall_pct = 30;
        repeat (6)
        begin
            send_instruction();
            wait_for_results();
        end
    endtask

    task automatic test_backpressure_fill();
        in_beat_t beat;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        -> hold_go;
        for (int i = 0; i < 120; i++)
        begin
            beat = op_beat($urandom_range(1) ? KIND_REMU : KIND_DIVU, 1'b1,
                           LANE_BITS'(i % LANES), pick_operand(), pick_operand());
            beat.swap_operands = 1'($urandom_range(1));
            beat.use_broadcast = 1'($urandom_range(1));
            beat.final_lane    = (i % LANES == LANES - 1);
            send_beat(beat);
        end
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        run_random_traffic(0, 0, 180);
    endtask

    task automatic test_sender_gaps();
        run_random_traffic(59, 0, 180);
    endtask

    task automatic test_receiver_stalls();
        run_random_traffic(0, 59, 180);
    endtask

    task automatic test_both_idle();
        run_random_traffic(18, 18, 180);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_pause_until_drained();
        test_backpressure_fill();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
